/* src/trn_pkg.sv */
// Shared constants and payload types of the transform row nlerp block.
package trn_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned BLEND_W   = 16;
  localparam int unsigned ROW_W     = 2;
  localparam int unsigned DIFF_W    = DATA_W + 1;
  localparam int unsigned PROD_W    = DIFF_W + BLEND_W + 1;
  localparam int unsigned SQ_W      = 2 * DATA_W;
  localparam int unsigned ROOT_W    = DATA_W;
  localparam int unsigned SREM_W    = ROOT_W + 4;
  localparam int unsigned QUO_W     = FRAC_BITS + 1;
  localparam int unsigned NUM_W     = DATA_W + QUO_W;
  localparam int unsigned DIV_STEPS = QUO_W;
  localparam int unsigned SQRT_STEPS = ROOT_W;

  localparam logic [ROW_W-1:0] RowPosition = ROW_W'(3);
  localparam logic signed [DATA_W-1:0] FixOne  = DATA_W'(64'd1 << FRAC_BITS);
  localparam logic signed [DATA_W-1:0] FixZero = '0;
  localparam logic signed [PROD_W-1:0] LerpHalf = PROD_W'(64'd1 << (BLEND_W - 1));

  typedef logic signed [DATA_W-1:0] word_t;

  typedef struct packed {
    logic [ROW_W-1:0] row;
    word_t [2:0]      v;
    word_t            w;
    logic             norm;
  } item_t;

  typedef struct packed {
    item_t             item;
    logic [SQ_W-1:0]   sq;
    logic [SREM_W-1:0] rem;
    logic [ROOT_W-1:0] root;
  } sqrt_t;

  typedef struct packed {
    item_t                   item;
    logic [2:0]              neg;
    logic [ROOT_W-1:0]       len;
    logic [2:0][ROOT_W-1:0]  rem;
    logic [2:0][QUO_W-1:0]   low;
    logic [2:0][QUO_W-1:0]   quo;
  } div_t;

endpackage

/* src/trn_sqrt_cell.sv */
// One digit cell of the pipelined integer square root chain.
module trn_sqrt_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  trn_pkg::sqrt_t data_i,
  output logic           valid_o,
  input  logic           ready_i,
  output trn_pkg::sqrt_t data_o
);

  logic                           valid_q;
  trn_pkg::sqrt_t                 data_q;
  trn_pkg::sqrt_t                 data_d;
  logic [trn_pkg::SREM_W-1:0]     rem_sh;
  logic [trn_pkg::SREM_W-1:0]     trial;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_comb begin
    rem_sh = {data_i.rem[trn_pkg::SREM_W-3:0], data_i.sq[trn_pkg::SQ_W-1 -: 2]};
    trial  = {2'b00, data_i.root, 2'b01};
    data_d = data_i;
    data_d.sq = {data_i.sq[trn_pkg::SQ_W-3:0], 2'b00};
    if (rem_sh >= trial) begin
      data_d.rem  = rem_sh - trial;
      data_d.root = {data_i.root[trn_pkg::ROOT_W-2:0], 1'b1};
    end else begin
      data_d.rem  = rem_sh;
      data_d.root = {data_i.root[trn_pkg::ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

/* src/trn_div_cell.sv */
// One quotient-bit cell of the three-lane pipelined restoring divider chain.
module trn_div_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  trn_pkg::div_t data_i,
  output logic          valid_o,
  input  logic          ready_i,
  output trn_pkg::div_t data_o
);

  logic                 valid_q;
  trn_pkg::div_t        data_q;
  trn_pkg::div_t        data_d;
  logic [2:0][trn_pkg::ROOT_W:0] rem_sh;
  logic [2:0]           take;

  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_comb begin
    data_d = data_i;
    for (int i = 0; i < 3; i++) begin
      rem_sh[i] = {data_i.rem[i], data_i.low[i][trn_pkg::QUO_W-1]};
      take[i]   = rem_sh[i] >= {1'b0, data_i.len};
      data_d.low[i] = {data_i.low[i][trn_pkg::QUO_W-2:0], 1'b0};
      data_d.quo[i] = {data_i.quo[i][trn_pkg::QUO_W-2:0], take[i]};
      if (take[i]) begin
        data_d.rem[i] = trn_pkg::ROOT_W'(rem_sh[i] - {1'b0, data_i.len});
      end else begin
        data_d.rem[i] = rem_sh[i][trn_pkg::ROOT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

endmodule

/* src/transform_row_nlerp_core.sv */
// Top level of the transform row nlerp block: interpolation, square root and divider chains.
//
// The block blends one row of two rigid transforms per transaction. The input
// channel (in_valid_i, in_ready_o) carries the row index, the row of A with its
// fourth column, the row of B and the blend weight. The output channel
// (out_valid_o, out_ready_i) returns the row index and the four blended columns.
// Axis rows are interpolated and scaled to unit length; the position row is
// interpolated only. A zero blend returns row A unchanged.
// The pipeline runs through the interpolation, squaring and summing stages,
// 32 cells of the square root chain (one root bit each), a setup stage,
// 17 cells of the divider chain (one quotient bit each) and the output register.
// Throughput is one transaction per cycle in steady state while the receiver is ready.
// Every stage holds its own valid bit, so a stalled receiver only stops the
// stages that are full; empty stages keep filling and the input stays ready
// until the whole chain is full.
// Reset clears all valid bits; the chain is empty and the output is invalid.
module transform_row_nlerp_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [trn_pkg::ROW_W-1:0]         row_i,
  input  logic signed [trn_pkg::DATA_W-1:0] a_x_i,
  input  logic signed [trn_pkg::DATA_W-1:0] a_y_i,
  input  logic signed [trn_pkg::DATA_W-1:0] a_z_i,
  input  logic signed [trn_pkg::DATA_W-1:0] a_w_i,
  input  logic signed [trn_pkg::DATA_W-1:0] b_x_i,
  input  logic signed [trn_pkg::DATA_W-1:0] b_y_i,
  input  logic signed [trn_pkg::DATA_W-1:0] b_z_i,
  input  logic [trn_pkg::BLEND_W-1:0]       blend_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [trn_pkg::ROW_W-1:0]         out_row_o,
  output logic signed [trn_pkg::DATA_W-1:0] out_x_o,
  output logic signed [trn_pkg::DATA_W-1:0] out_y_o,
  output logic signed [trn_pkg::DATA_W-1:0] out_z_o,
  output logic signed [trn_pkg::DATA_W-1:0] out_w_o
);

  // Stage 1: differences times blend.
  logic                                    s1_valid_q;
  logic                                    s1_ready;
  logic [trn_pkg::ROW_W-1:0]               s1_row_q;
  logic                                    s1_zero_q;
  logic [2:0][trn_pkg::DATA_W-1:0]         s1_a_q;
  logic [trn_pkg::DATA_W-1:0]              s1_aw_q;
  logic [2:0][trn_pkg::PROD_W-1:0]         s1_prod_q;
  logic [2:0][trn_pkg::PROD_W-1:0]         s1_prod_d;
  logic [2:0][trn_pkg::DATA_W-1:0]         in_a;
  logic [2:0][trn_pkg::DATA_W-1:0]         in_b;
  logic signed [trn_pkg::DIFF_W-1:0]       diff;

  // Stage 2: interpolated row.
  logic                                    s2_valid_q;
  logic                                    s2_ready;
  trn_pkg::item_t                          s2_item_q;
  trn_pkg::item_t                          s2_item_d;
  logic signed [trn_pkg::PROD_W-1:0]       rnd;

  // Stage 3: squares.
  logic                                    s3_valid_q;
  logic                                    s3_ready;
  trn_pkg::item_t                          s3_item_q;
  logic [2:0][trn_pkg::SQ_W-1:0]           s3_sq_q;
  logic [2:0][trn_pkg::SQ_W-1:0]           s3_sq_d;

  // Square root chain, whose input register is the sum stage.
  logic           sq_valid [0:trn_pkg::SQRT_STEPS];
  logic           sq_ready [0:trn_pkg::SQRT_STEPS+1];
  trn_pkg::sqrt_t sq_data  [0:trn_pkg::SQRT_STEPS];
  logic           s4_valid_q;
  trn_pkg::sqrt_t s4_data_q;
  trn_pkg::sqrt_t s4_data_d;

  // Divider chain, whose input register is the setup stage.
  logic           dv_valid [0:trn_pkg::DIV_STEPS];
  logic           dv_ready [0:trn_pkg::DIV_STEPS+1];
  trn_pkg::div_t  dv_data  [0:trn_pkg::DIV_STEPS];
  logic           dp_valid_q;
  trn_pkg::div_t  dp_data_q;
  trn_pkg::div_t  dp_data_d;
  logic [trn_pkg::ROOT_W-1:0] mag;
  logic [trn_pkg::NUM_W-1:0]  num;

  // Output register.
  logic                            out_valid_q;
  logic                            out_ready;
  logic [trn_pkg::ROW_W-1:0]       out_row_q;
  logic [3:0][trn_pkg::DATA_W-1:0] out_col_q;
  logic [3:0][trn_pkg::DATA_W-1:0] out_col_d;
  logic [trn_pkg::DATA_W-1:0]      qext;

  // Stage 1.
  assign in_a = {a_z_i, a_y_i, a_x_i};
  assign in_b = {b_z_i, b_y_i, b_x_i};
  assign s1_ready   = !s1_valid_q || s2_ready;
  assign in_ready_o = s1_ready;

  always_comb begin
    diff = '0;
    for (int i = 0; i < 3; i++) begin
      diff = trn_pkg::DIFF_W'($signed(in_b[i])) - trn_pkg::DIFF_W'($signed(in_a[i]));
      s1_prod_d[i] = trn_pkg::PROD_W'(diff * $signed({1'b0, blend_i}));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_ready) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i) begin
      s1_row_q  <= row_i;
      s1_zero_q <= (blend_i == '0);
      s1_a_q    <= in_a;
      s1_aw_q   <= a_w_i;
      s1_prod_q <= s1_prod_d;
    end
  end

  // Stage 2.
  assign s2_ready = !s2_valid_q || s3_ready;

  always_comb begin
    rnd = '0;
    s2_item_d.row = s1_row_q;
    for (int i = 0; i < 3; i++) begin
      rnd = ($signed(s1_prod_q[i]) + trn_pkg::LerpHalf) >>> trn_pkg::BLEND_W;
      if (s1_zero_q) begin
        s2_item_d.v[i] = s1_a_q[i];
      end else begin
        s2_item_d.v[i] = s1_a_q[i] + rnd[trn_pkg::DATA_W-1:0];
      end
    end
    if (s1_zero_q) begin
      s2_item_d.w    = s1_aw_q;
      s2_item_d.norm = 1'b0;
    end else if (s1_row_q == trn_pkg::RowPosition) begin
      s2_item_d.w    = trn_pkg::FixOne;
      s2_item_d.norm = 1'b0;
    end else begin
      s2_item_d.w    = trn_pkg::FixZero;
      s2_item_d.norm = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_ready) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_ready && s1_valid_q) begin
      s2_item_q <= s2_item_d;
    end
  end

  // Stage 3.
  assign s3_ready = !s3_valid_q || sq_ready[0];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s3_sq_d[i] = trn_pkg::SQ_W'($signed(s2_item_q.v[i]) * $signed(s2_item_q.v[i]));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (s3_ready) begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_ready && s2_valid_q) begin
      s3_item_q <= s2_item_q;
      s3_sq_q   <= s3_sq_d;
    end
  end

  // Stage 4: sum of squares, start of the square root chain.
  assign sq_ready[0] = !s4_valid_q || sq_ready[1];
  assign sq_valid[0] = s4_valid_q;
  assign sq_data[0]  = s4_data_q;
  assign sq_ready[trn_pkg::SQRT_STEPS+1] = dv_ready[0];

  always_comb begin
    s4_data_d.item = s3_item_q;
    s4_data_d.sq   = s3_sq_q[0] + s3_sq_q[1] + s3_sq_q[2];
    s4_data_d.rem  = '0;
    s4_data_d.root = '0;
    s4_data_d.item.norm = s3_item_q.norm && (s4_data_d.sq != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q <= 1'b0;
    end else if (sq_ready[0]) begin
      s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sq_ready[0] && s3_valid_q) begin
      s4_data_q <= s4_data_d;
    end
  end

  for (genvar j = 1; j <= trn_pkg::SQRT_STEPS; j++) begin : g_sqrt
    trn_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (sq_valid[j-1]),
      .ready_o (sq_ready[j]),
      .data_i  (sq_data[j-1]),
      .valid_o (sq_valid[j]),
      .ready_i (sq_ready[j+1]),
      .data_o  (sq_data[j])
    );
  end

  // Divider setup stage.
  assign dv_ready[0] = !dp_valid_q || dv_ready[1];
  assign dv_valid[0] = dp_valid_q;
  assign dv_data[0]  = dp_data_q;
  assign dv_ready[trn_pkg::DIV_STEPS+1] = out_ready;

  always_comb begin
    mag = '0;
    num = '0;
    dp_data_d.item = sq_data[trn_pkg::SQRT_STEPS].item;
    dp_data_d.len  = sq_data[trn_pkg::SQRT_STEPS].root;
    for (int i = 0; i < 3; i++) begin
      dp_data_d.neg[i] = sq_data[trn_pkg::SQRT_STEPS].item.v[i][trn_pkg::DATA_W-1];
      if (dp_data_d.neg[i]) begin
        mag = trn_pkg::ROOT_W'(-sq_data[trn_pkg::SQRT_STEPS].item.v[i]);
      end else begin
        mag = sq_data[trn_pkg::SQRT_STEPS].item.v[i];
      end
      num = {1'b0, mag, trn_pkg::FRAC_BITS'(0)}
          + trn_pkg::NUM_W'(dp_data_d.len >> 1);
      dp_data_d.rem[i] = num[trn_pkg::NUM_W-1 -: trn_pkg::ROOT_W];
      dp_data_d.low[i] = num[trn_pkg::QUO_W-1:0];
      dp_data_d.quo[i] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dp_valid_q <= 1'b0;
    end else if (dv_ready[0]) begin
      dp_valid_q <= sq_valid[trn_pkg::SQRT_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (dv_ready[0] && sq_valid[trn_pkg::SQRT_STEPS]) begin
      dp_data_q <= dp_data_d;
    end
  end

  for (genvar j = 1; j <= trn_pkg::DIV_STEPS; j++) begin : g_div
    trn_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (dv_valid[j-1]),
      .ready_o (dv_ready[j]),
      .data_i  (dv_data[j-1]),
      .valid_o (dv_valid[j]),
      .ready_i (dv_ready[j+1]),
      .data_o  (dv_data[j])
    );
  end

  // Output register: sign and selection.
  assign out_ready = !out_valid_q || out_ready_i;

  always_comb begin
    qext = '0;
    for (int i = 0; i < 3; i++) begin
      qext = trn_pkg::DATA_W'(dv_data[trn_pkg::DIV_STEPS].quo[i]);
      if (!dv_data[trn_pkg::DIV_STEPS].item.norm) begin
        out_col_d[i] = dv_data[trn_pkg::DIV_STEPS].item.v[i];
      end else if (dv_data[trn_pkg::DIV_STEPS].neg[i]) begin
        out_col_d[i] = -qext;
      end else begin
        out_col_d[i] = qext;
      end
    end
    out_col_d[3] = dv_data[trn_pkg::DIV_STEPS].item.w;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= dv_valid[trn_pkg::DIV_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && dv_valid[trn_pkg::DIV_STEPS]) begin
      out_row_q <= dv_data[trn_pkg::DIV_STEPS].item.row;
      out_col_q <= out_col_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_row_o   = out_row_q;
  assign out_x_o     = out_col_q[0];
  assign out_y_o     = out_col_q[1];
  assign out_z_o     = out_col_q[2];
  assign out_w_o     = out_col_q[3];

endmodule

/* dv/tb_transform_row_nlerp_core.sv */
// Self-checking testbench of the transform row nlerp block with a built-in row predictor.
module tb_transform_row_nlerp_core;

  typedef struct {
    logic [trn_pkg::ROW_W-1:0] row;
    trn_pkg::word_t x, y, z, w;
  } row_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [trn_pkg::ROW_W-1:0] row_i = '0;
  trn_pkg::word_t a_x_i = '0, a_y_i = '0, a_z_i = '0, a_w_i = '0;
  trn_pkg::word_t b_x_i = '0, b_y_i = '0, b_z_i = '0;
  logic [trn_pkg::BLEND_W-1:0] blend_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [trn_pkg::ROW_W-1:0] out_row_o;
  trn_pkg::word_t out_x_o, out_y_o, out_z_o, out_w_o;

  row_res_t blended_q[$];
  int unsigned err_cnt = 0;
  int unsigned idle_cnt = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct = 0;
  bit hold_off = 1'b0;

  transform_row_nlerp_core u_dut (.*);

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint lerp_axis(longint a, longint b, longint t);
    longint p;
    p = (b - a) * t + 64'sd32768;
    return a + (p >>> trn_pkg::BLEND_W);
  endfunction

  function automatic longint unsigned root_floor(longint unsigned n);
    longint unsigned r, bt;
    r = 0;
    bt = 64'd1 << 62;
    while (bt > n) bt = bt >> 2;
    while (bt != 0) begin
      if (n >= r + bt) begin
        n = n - (r + bt);
        r = (r >> 1) + bt;
      end else begin
        r = r >> 1;
      end
      bt = bt >> 2;
    end
    return r;
  endfunction

  function automatic longint to_unit(longint c, longint unsigned len);
    longint unsigned m, q;
    m = (c < 0) ? longint'(-c) : c;
    q = ((m << trn_pkg::FRAC_BITS) + (len >> 1)) / len;
    return (c < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic row_res_t blend_row(logic [trn_pkg::ROW_W-1:0] row,
      trn_pkg::word_t ax, trn_pkg::word_t ay, trn_pkg::word_t az, trn_pkg::word_t aw,
      trn_pkg::word_t bx, trn_pkg::word_t by, trn_pkg::word_t bz,
      logic [trn_pkg::BLEND_W-1:0] t);
    row_res_t r;
    longint v[3];
    longint unsigned s, len, m;
    r.row = row;
    if (t == 0) begin
      r.x = ax; r.y = ay; r.z = az; r.w = aw;
      return r;
    end
    v[0] = lerp_axis(ax, bx, t);
    v[1] = lerp_axis(ay, by, t);
    v[2] = lerp_axis(az, bz, t);
    if (row == trn_pkg::RowPosition) begin
      r.w = trn_pkg::FixOne;
    end else begin
      r.w = trn_pkg::FixZero;
      s = 0;
      for (int i = 0; i < 3; i++) begin
        m = (v[i] < 0) ? longint'(-v[i]) : v[i];
        s = s + m * m;
      end
      if (s != 0) begin
        len = root_floor(s);
        for (int i = 0; i < 3; i++) v[i] = to_unit(v[i], len);
      end
    end
    r.x = trn_pkg::word_t'(v[0]);
    r.y = trn_pkg::word_t'(v[1]);
    r.z = trn_pkg::word_t'(v[2]);
    return r;
  endfunction

  task automatic send_row(logic [trn_pkg::ROW_W-1:0] row,
      trn_pkg::word_t ax, trn_pkg::word_t ay, trn_pkg::word_t az, trn_pkg::word_t aw,
      trn_pkg::word_t bx, trn_pkg::word_t by, trn_pkg::word_t bz,
      logic [trn_pkg::BLEND_W-1:0] t);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    row_i <= row;
    a_x_i <= ax; a_y_i <= ay; a_z_i <= az; a_w_i <= aw;
    b_x_i <= bx; b_y_i <= by; b_z_i <= bz;
    blend_i <= t;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    blended_q.insert(blended_q.size(), blend_row(row, ax, ay, az, aw, bx, by, bz, t));
  endtask

  task automatic send_gap();
    in_valid_i <= 1'b0;
  endtask

  function automatic trn_pkg::word_t rand_word();
    case ($urandom_range(5))
      0: return trn_pkg::word_t'($urandom_range(255)) - 128;
      1: return 32'sh8000_0000;
      2: return 32'sh7fff_ffff;
      3: return trn_pkg::word_t'($urandom_range(131072)) - 65536;
      default: return trn_pkg::word_t'($urandom);
    endcase
  endfunction

  function automatic logic [trn_pkg::BLEND_W-1:0] rand_blend();
    case ($urandom_range(5))
      0: return '0;
      1: return 16'hffff;
      2: return 16'h8000;
      default: return trn_pkg::BLEND_W'($urandom);
    endcase
  endfunction

  task automatic send_random(int unsigned n);
    for (int unsigned k = 0; k < n; k++) begin
      send_row(trn_pkg::ROW_W'($urandom), rand_word(), rand_word(), rand_word(), rand_word(),
               rand_word(), rand_word(), rand_word(), rand_blend());
    end
    send_gap();
  endtask

  task automatic wait_drained();
    while (blended_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed();
    trn_pkg::word_t mn, mx;
    mn = 32'sh8000_0000;
    mx = 32'sh7fff_ffff;
    for (int r = 0; r < 4; r++) begin
      send_row(trn_pkg::ROW_W'(r), mn, mx, mn, mx, mx, mn, mx, 16'h0000);
      send_row(trn_pkg::ROW_W'(r), mn, mx, mn, mx, mx, mn, mx, 16'hffff);
      send_row(trn_pkg::ROW_W'(r), mn, mn, mn, 0, mx, mx, mx, 16'h8000);
    end
    send_row(0, 0, 0, 0, 5, 0, 0, 0, 16'h1234);
    send_row(1, 100, -100, 0, 0, -100, 100, 0, 16'h8000);
    send_row(2, trn_pkg::FixOne, 0, 0, 0, 0, trn_pkg::FixOne, 0, 16'h0001);
    send_row(3, mx, mx, mx, mn, mn, mn, mn, 16'h0001);
    send_row(0, -1, -1, -1, -1, 1, 1, 1, 16'h7fff);
    send_row(1, 3, 4, 0, 0, 3, 4, 0, 16'hffff);
    send_row(2, 0, 0, 0, 0, 0, 0, 1, 16'h0001);
    send_gap();
    wait_drained();
  endtask

  task automatic test_no_idling();
    send_idle_pct = 0; stall_pct = 0;
    send_random(200);
    wait_drained();
  endtask

  task automatic test_sender_idle();
    send_idle_pct = 77; stall_pct = 0;
    send_random(150);
    wait_drained();
  endtask

  task automatic test_receiver_stall();
    send_idle_pct = 0; stall_pct = 77;
    send_random(150);
    wait_drained();
  endtask

  task automatic test_both_idle();
    send_idle_pct = 20; stall_pct = 20;
    send_random(150);
    wait_drained();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0; stall_pct = 0;
    hold_off = 1'b1;
    send_random(100);
    wait_drained();
  endtask

  // Receiver: random stalls, plus one long hold-off to fill the pipeline.
  initial begin
    int unsigned hold_cnt;
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        hold_cnt = 0;
        out_ready_i <= 1'b0;
        while (hold_cnt < 200) begin
          @(posedge clk_i);
          hold_cnt++;
        end
        hold_off = 1'b0;
      end
      out_ready_i <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    row_res_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (blended_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("Unexpected transaction: row %0d", out_row_o);
      end else begin
        e = blended_q.pop_front();
        if (e.row !== out_row_o || e.x !== out_x_o || e.y !== out_y_o ||
            e.z !== out_z_o || e.w !== out_w_o) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("Mismatch: expected row %0d %h %h %h %h, got row %0d %h %h %h %h",
                     e.row, e.x, e.y, e.z, e.w,
                     out_row_o, out_x_o, out_y_o, out_z_o, out_w_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i))
      idle_cnt <= 0;
    else
      idle_cnt <= idle_cnt + 1;
  end

  initial begin
    wait (idle_cnt >= 5000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_no_idling();
    test_sender_idle();
    test_receiver_stall();
    test_both_idle();
    test_backpressure();
    repeat (100) @(posedge clk_i);
    if (err_cnt == 0 && blended_q.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
